### sv/dait_pkg.sv
// Shared types and constants for the DAO induction detect table.
// Depends on nothing; every other file refers to it by scoped names.
package dait_pkg;

   // Status codes carried in the result
   localparam logic [2:0] ST_SAME    = 3'd0;
   localparam logic [2:0] ST_GRACE   = 3'd1;
   localparam logic [2:0] ST_SUSPECT = 3'd2;
   localparam logic [2:0] ST_NEW     = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   // Grace window after reset, in ticks
   localparam logic [31:0] GRACE_RESET = 32'd3840;

   typedef struct packed {
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [7:0]  seq_number;
      logic [31:0] now_time;
      logic [31:0] root_update_time;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] previous_seq;
      logic [3:0] slot_index;
   } rsp_type;

   // One stored table entry
   typedef struct packed {
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [7:0]  seq;
   } entry_type;

endpackage

### sv/dait_store.sv
// Entry memory of the DAO induction detect table: one write port and one
// registered read port. Depends on dait_pkg for the entry type.
module dait_store #(
   parameter int TABLE_ENTRIES = 16,
   parameter int IDX_W         = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  dait_pkg::entry_type wr_data,
   input  logic [IDX_W-1:0]    rd_addr,
   output dait_pkg::entry_type rd_data
);

   dait_pkg::entry_type mem [TABLE_ENTRIES];
   dait_pkg::entry_type rd_data_ff;

   // Write one entry, read one entry into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/dait_walk.sv
// Sequencer of the DAO induction detect table: walks the entry memory one
// slot a cycle through a shared 128-bit address compare, then updates it.
// Depends on dait_pkg and drives the dait_store ports.
module dait_walk #(
   parameter int TABLE_ENTRIES = 16,
   parameter int IDX_W         = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         grace_ticks,
   input  logic                req_valid,
   output logic                req_ready,
   input  dait_pkg::req_type   req_data,
   output logic                done_valid,
   input  logic                done_ready,
   output dait_pkg::rsp_type   done_data,
   output logic                wr_en,
   output logic [IDX_W-1:0]    wr_addr,
   output dait_pkg::entry_type wr_data,
   output logic [IDX_W-1:0]    rd_addr,
   input  dait_pkg::entry_type rd_data
);

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [1:0] {
      IDLE,
      WALK,
      FINISH
   } state_type;

   state_type                  state_ff, state_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   dait_pkg::req_type          item_ff, item_in;
   logic                       trig_ff, trig_in;
   logic                       hit_ff, hit_in;
   logic [IDX_W-1:0]           hit_slot_ff, hit_slot_in;
   logic [7:0]                 prev_ff, prev_in;
   logic                       free_ff, free_in;
   logic [IDX_W-1:0]           free_slot_ff, free_slot_in;
   logic [TABLE_ENTRIES-1:0]   valid_ff, valid_in;

   logic [31:0]                age;
   logic                       addr_eq;
   logic [IDX_W-1:0]           slot_sel;
   logic [IDX_W+3:0]           slot_wide;
   logic [2:0]                 status;

   // Grace test on the arriving item: modular age against the window
   assign age = req_data.now_time - req_data.root_update_time;

   // Shared compare unit: stored sender against the held sender
   assign addr_eq = (rd_data.addr_high == item_ff.addr_high) &&
                    (rd_data.addr_low == item_ff.addr_low);

   assign req_ready = (state_ff == IDLE);

   // Next state and walk bookkeeping
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      item_in      = item_ff;
      trig_in      = trig_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      prev_in      = prev_ff;
      free_in      = free_ff;
      free_slot_in = free_slot_ff;
      valid_in     = valid_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               state_in = WALK;
               idx_in   = '0;
               item_in  = req_data;
               trig_in  = (req_data.root_update_time != 32'd0) && (age <= grace_ticks);
               hit_in   = 1'b0;
               free_in  = 1'b0;
            end
         end
         WALK: begin
            if (valid_ff[idx_ff]) begin
               if (addr_eq) begin
                  hit_in      = 1'b1;
                  hit_slot_in = idx_ff;
                  prev_in     = rd_data.seq;
                  state_in    = FINISH;
               end
            end else if (!free_ff) begin
               free_in      = 1'b1;
               free_slot_in = idx_ff;
            end
            if (idx_ff == LAST_SLOT) begin
               state_in = FINISH;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         FINISH: begin
            if (done_ready) begin
               state_in = IDLE;
               if (!hit_ff && free_ff) begin
                  valid_in[free_slot_ff] = 1'b1;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // Hold state, walk position and the item under work
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      idx_ff       <= idx_in;
      item_ff      <= item_in;
      trig_ff      <= trig_in;
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      prev_ff      <= prev_in;
      free_ff      <= free_in;
      free_slot_ff <= free_slot_in;
   end

   // Read one slot ahead of the compare; idle parks on slot zero
   always_comb begin
      if (state_ff == WALK && idx_ff != LAST_SLOT) begin
         rd_addr = idx_ff + IDX_W'(1);
      end else if (state_ff == WALK) begin
         rd_addr = idx_ff;
      end else begin
         rd_addr = '0;
      end
   end

   // Result of the walk
   always_comb begin
      if (hit_ff) begin
         if (prev_ff == item_ff.seq_number) begin
            status = dait_pkg::ST_SAME;
         end else if (trig_ff) begin
            status = dait_pkg::ST_GRACE;
         end else begin
            status = dait_pkg::ST_SUSPECT;
         end
      end else if (free_ff) begin
         status = dait_pkg::ST_NEW;
      end else begin
         status = dait_pkg::ST_FULL;
      end
   end

   assign slot_sel  = hit_ff ? hit_slot_ff : free_slot_ff;
   assign slot_wide = {4'b0000, slot_sel};

   assign done_valid             = (state_ff == FINISH);
   assign done_data.status       = status;
   assign done_data.previous_seq = hit_ff ? prev_ff : 8'd0;
   assign done_data.slot_index   = (hit_ff || free_ff) ? slot_wide[3:0] : 4'd0;

   // Store the new seqno on a match, or the new sender in the free slot
   assign wr_en             = (state_ff == FINISH) && done_ready && (hit_ff || free_ff);
   assign wr_addr           = slot_sel;
   assign wr_data.addr_high = item_ff.addr_high;
   assign wr_data.addr_low  = item_ff.addr_low;
   assign wr_data.seq       = item_ff.seq_number;

endmodule

### sv/dao_induction_detect_table.sv
// DAO induction detect table: top level with the grace register and the
// result register. Depends on dait_pkg, dait_store and dait_walk.
//
// Usage: present one received DAO on req_ (valid/ready); each transfer
// yields exactly one result on rsp_ (valid/ready) with a status, the seqno
// stored before the update and the slot used. csr_wr_en writes grace_ticks
// from csr_wr_data at once; write it only while the block is idle.
// Timing: after a request transfer the sequencer walks the table one slot
// a cycle through a single address compare and stops at the first match
// or after the last slot on a miss, then updates the table. The walk is
// set by the one read port of the entry memory. The result sits in an
// output register, so a new request is taken while it waits.
// A stalled receiver holds the result; a second finished item then waits
// in the update step until the output register frees.
// Reset clears all table valid bits at once, sets grace_ticks to 3840 and
// empties the output register; entries are never evicted afterwards.
module dao_induction_detect_table #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dait_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dait_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic [31:0]         grace_ff;
   logic                rsp_valid_ff;
   dait_pkg::rsp_type   rsp_data_ff;

   logic                done_valid;
   logic                done_ready;
   dait_pkg::rsp_type   done_data;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   dait_pkg::entry_type wr_data;
   logic [IDX_W-1:0]    rd_addr;
   dait_pkg::entry_type rd_data;

   // Hold the grace window
   always_ff @(posedge clock) begin
      if (reset) begin
         grace_ff <= dait_pkg::GRACE_RESET;
      end else if (csr_wr_en) begin
         grace_ff <= csr_wr_data;
      end
   end

   // Result register: load when empty or draining, drop after transfer
   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_ready) begin
         rsp_valid_ff <= done_valid;
      end
      if (done_ready && done_valid) begin
         rsp_data_ff <= done_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   dait_walk #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .grace_ticks (grace_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_data   (done_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   dait_store #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
